### sv/swm_pkg.sv
// Package for the sliding window minimum block: payload structs, controller
// command and status structs, and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package swm_pkg;

   localparam int SAMPLE_W           = 32;
   localparam int WINDOW_LEN_W       = 9;
   localparam int MAX_WINDOW_DEFAULT = 256;
   localparam logic [WINDOW_LEN_W-1:0] WINDOW_LEN_RESET = 9'd20;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       series_start;
      logic                       lead_skip;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] low_value;
      logic                       low_valid;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // latch the accepted request
      logic update;   // store sample, advance pointers, maybe start a rescan
      logic scan;     // let the rescan issue reads
      logic emit;     // load the response register
   } swm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;
      logic scan_busy;
      logic out_free;
   } swm_status_type;

endpackage

### sv/swm_dpath.sv
// Datapath of the sliding window minimum: sample store, ring pointers,
// running minimum, rescan address generator and response register.
// Depends on swm_pkg; driven by swm_ctrl.
`timescale 1ns / 1ps

module swm_dpath #(
   parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  swm_pkg::req_payload_type              req_payload,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output swm_pkg::rsp_payload_type              rsp_payload,
   input  logic                                  csr_we,
   input  logic [swm_pkg::WINDOW_LEN_W-1:0]      csr_wdata,
   input  swm_pkg::swm_cmd_type                  cmd,
   output swm_pkg::swm_status_type               status
);
   import swm_pkg::*;

   localparam int PW = $clog2(MAX_WINDOW);
   localparam int LW = $clog2(MAX_WINDOW + 1);
   localparam int NW = (LW > WINDOW_LEN_W) ? LW : WINDOW_LEN_W;
   localparam logic [LW-1:0] MAX_L  = LW'(MAX_WINDOW);
   localparam logic [PW-1:0] LAST_P = PW'(MAX_WINDOW - 1);

   logic [SAMPLE_W-1:0] store_mem [MAX_WINDOW];

   logic [WINDOW_LEN_W-1:0] wlen_ff, wlen_in;
   logic [SAMPLE_W-1:0]     sample_ff, sample_in;
   logic                    skip_ff, skip_in;
   logic [PW-1:0]           wp_ff, wp_in;
   logic [LW-1:0]           vc_ff, vc_in;
   logic [SAMPLE_W-1:0]     cur_ff, cur_in;
   logic [PW-1:0]           pos_ff, pos_in;
   logic                    res_ok_ff, res_ok_in;
   logic [PW-1:0]           scan_addr_ff, scan_addr_in;
   logic [LW-1:0]           left_ff, left_in;
   logic                    first_ff, first_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic                    rd_first_ff, rd_first_in;
   logic [PW-1:0]           rd_addr_ff, rd_addr_in;
   logic [SAMPLE_W-1:0]     rd_data_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_payload_ff, rsp_payload_in;

   logic [NW-1:0] wlen_x;
   logic [LW-1:0] n_eff, vc_new, wp_x, pos_x, ring_gap, k, km1, start;
   logic          cum, need_scan, less_new, take_new, issue, take_rd;
   logic [PW-1:0] wp_next, addr_next;

   always_comb begin
      wlen_x   = NW'(wlen_ff);
      n_eff    = (wlen_x > NW'(MAX_WINDOW)) ? MAX_L : LW'(wlen_x);
      cum      = (n_eff == '0);
      vc_new   = (vc_ff < MAX_L) ? vc_ff + LW'(1) : vc_ff;
      wp_x     = LW'(wp_ff);
      pos_x    = LW'(pos_ff);
      // ring distance from the minimum to the slot about to be written
      ring_gap = (wp_x >= pos_x) ? wp_x - pos_x : wp_x + MAX_L - pos_x;
      if (ring_gap == '0) begin
         ring_gap = MAX_L;
      end
      need_scan = !skip_ff && !cum && ((vc_ff == '0) || (ring_gap >= n_eff));
      k        = (vc_new < n_eff) ? vc_new : n_eff;
      km1      = k - LW'(1);
      start    = (wp_x >= km1) ? wp_x - km1 : wp_x + MAX_L - km1;
      less_new = $signed(sample_ff) < $signed(cur_ff);
      take_new = !skip_ff && (cum ? ((vc_ff == '0) || less_new) : (!need_scan && less_new));
      wp_next  = (wp_ff == LAST_P) ? '0 : wp_ff + PW'(1);
      addr_next = (scan_addr_ff == LAST_P) ? '0 : scan_addr_ff + PW'(1);
      issue    = cmd.scan && (left_ff != '0);
      // strict compare keeps the oldest position on ties
      take_rd  = rd_vld_ff && (rd_first_ff || ($signed(rd_data_ff) < $signed(cur_ff)));
   end

   always_comb begin
      wlen_in        = wlen_ff;
      sample_in      = sample_ff;
      skip_in        = skip_ff;
      wp_in          = wp_ff;
      vc_in          = vc_ff;
      cur_in         = cur_ff;
      pos_in         = pos_ff;
      res_ok_in      = res_ok_ff;
      scan_addr_in   = scan_addr_ff;
      left_in        = left_ff;
      first_in       = first_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (csr_we) begin
         wlen_in = csr_wdata;
         wp_in   = '0;
         vc_in   = '0;
         cur_in  = '0;
         pos_in  = '0;
      end else if (cmd.load) begin
         sample_in = req_payload.sample;
         skip_in   = req_payload.lead_skip;
         if (req_payload.series_start) begin
            wp_in  = '0;
            vc_in  = '0;
            cur_in = '0;
            pos_in = '0;
         end
      end

      if (cmd.update) begin
         res_ok_in = !skip_ff && (cum || (vc_new >= n_eff));
         if (!skip_ff) begin
            vc_in = vc_new;
            wp_in = wp_next;
         end
         if (take_new) begin
            cur_in = sample_ff;
            pos_in = wp_ff;
         end
         if (need_scan) begin
            scan_addr_in = PW'(start);
            left_in      = k;
            first_in     = 1'b1;
         end
      end

      if (issue) begin
         scan_addr_in = addr_next;
         left_in      = left_ff - LW'(1);
         first_in     = 1'b0;
      end
      rd_vld_in   = issue;
      rd_first_in = issue && first_ff;
      rd_addr_in  = scan_addr_ff;

      if (take_rd) begin
         cur_in = rd_data_ff;
         pos_in = rd_addr_ff;
      end

      if (cmd.emit) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.low_value = res_ok_ff ? $signed(cur_ff) : '0;
         rsp_payload_in.low_valid = res_ok_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff      <= WINDOW_LEN_RESET;
         wp_ff        <= '0;
         vc_ff        <= '0;
         cur_ff       <= '0;
         pos_ff       <= '0;
         scan_addr_ff <= '0;
         left_ff      <= '0;
         first_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wlen_ff      <= wlen_in;
         wp_ff        <= wp_in;
         vc_ff        <= vc_in;
         cur_ff       <= cur_in;
         pos_ff       <= pos_in;
         scan_addr_ff <= scan_addr_in;
         left_ff      <= left_in;
         first_ff     <= first_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff      <= sample_in;
      skip_ff        <= skip_in;
      res_ok_ff      <= res_ok_in;
      rd_first_ff    <= rd_first_in;
      rd_addr_ff     <= rd_addr_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // sample store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.update && !skip_ff) begin
         store_mem[wp_ff] <= sample_ff;
      end
      if (issue) begin
         rd_data_ff <= store_mem[scan_addr_ff];
      end
   end

   assign status.need_scan = need_scan;
   assign status.scan_busy = (left_ff != '0) || rd_vld_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_payload_ff;

`ifndef SYNTHESIS
   a_ptr_range : assert property (@(posedge clock) disable iff (reset)
      (wp_ff <= LAST_P) && (pos_ff <= LAST_P) && (scan_addr_ff <= LAST_P))
      else $error("ring pointer out of range");
   a_count_sat : assert property (@(posedge clock) disable iff (reset)
      (vc_ff <= MAX_L) && (left_ff <= MAX_L))
      else $error("sample count above store depth");
   a_read_follows_issue : assert property (@(posedge clock) disable iff (reset)
      issue |=> rd_vld_ff && (rd_addr_ff == $past(scan_addr_ff)))
      else $error("rescan read lost");
`endif

endmodule

### sv/swm_ctrl.sv
// Controller of the sliding window minimum: sequences accept, update,
// rescan and response load. Depends on swm_pkg; drives swm_dpath.
`timescale 1ns / 1ps

module swm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  swm_pkg::swm_status_type status,
   output swm_pkg::swm_cmd_type    cmd
);
   import swm_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      UPDATE,
      SCAN,
      EMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;

   always_comb begin
      cmd.load   = req_valid && req_ready_ff;
      cmd.update = (state_ff == UPDATE);
      cmd.scan   = (state_ff == SCAN);
      cmd.emit   = (state_ff == EMIT) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= UPDATE;
                  req_ready_ff <= 1'b0;
               end
            end
            UPDATE: begin
               state_ff <= status.need_scan ? SCAN : EMIT;
            end
            SCAN: begin
               // wait for the last read to be compared
               if (!status.scan_busy) begin
                  state_ff <= EMIT;
               end
            end
            EMIT: begin
               if (status.out_free) begin
                  state_ff     <= IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;

`ifndef SYNTHESIS
   a_load_to_update : assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == UPDATE) && !req_ready_ff)
      else $error("accepted request not processed");
   a_ready_only_idle : assert property (@(posedge clock) disable iff (reset)
      req_ready_ff |-> (state_ff == IDLE))
      else $error("ready outside idle");
   a_emit_once : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !cmd.emit)
      else $error("response loaded twice");
`endif

endmodule

### sv/sliding_window_minimum.sv
// Sliding window minimum. A request passes accept, update and response load
// when no rescan is needed; a rescan sits between update and response load and
// reads k = min(samples seen, window length) stored samples, one store read per
// cycle, then drains. A new request is accepted only once the last response is
// loaded, which waits while the receiver holds the response register.
// Reset is synchronous: window_len returns to 20 and history clears; the
// sample store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module sliding_window_minimum #(
   parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  swm_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output swm_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_we,
   input  logic [swm_pkg::WINDOW_LEN_W-1:0] csr_wdata
);
   import swm_pkg::*;

   swm_cmd_type    cmd;
   swm_status_type status;

   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swm_dpath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

### sim/sliding_window_minimum_test.sv
// Self-checking test of sliding_window_minimum: directed and random requests under
// varied handshake idling, each response checked against an in-bench window predictor.
// Depends on swm_pkg and sliding_window_minimum.
`timescale 1ns / 1ps

module sliding_window_minimum_test;

   import swm_pkg::*;

   localparam int STORE_DEPTH = MAX_WINDOW_DEFAULT;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;

   typedef enum int unsigned {SCATTER, CLUSTERED, RISING, FALLING} shape_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_payload_type         req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_payload_type         rsp_payload;
   logic                    csr_we = 1'b0;
   logic [WINDOW_LEN_W-1:0] csr_wdata = '0;

   // predictor state
   logic signed [SAMPLE_W-1:0] hist [STORE_DEPTH];
   logic signed [SAMPLE_W-1:0] low_now = '0;
   int unsigned head = 0;
   int unsigned fill = 0;
   int unsigned low_at = 0;
   int unsigned win_len = WINDOW_LEN_RESET;

   rsp_payload_type expected_lows[$];

   int unsigned send_idle_pct = 23;
   int unsigned recv_idle_pct = 83;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left = 0;
   bit          hold_ask = 1'b0;

   sliding_window_minimum uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void clear_history();
      head = 0;
      fill = 0;
      low_now = '0;
      low_at = 0;
   endfunction

   function automatic rsp_payload_type predict_low(input req_payload_type r);
      rsp_payload_type res;
      int unsigned n, prev, gap, k, idx;
      res = '0;
      if (r.series_start) clear_history();
      if (r.lead_skip) return res;
      n = (win_len > STORE_DEPTH) ? STORE_DEPTH : win_len;
      prev = fill;
      hist[head] = r.sample;
      if (fill < STORE_DEPTH) fill++;
      if (n == 0) begin
         if (prev == 0 || r.sample < low_now) begin
            low_now = r.sample;
            low_at = head;
         end
      end else begin
         gap = (head + STORE_DEPTH - low_at) % STORE_DEPTH;
         if (gap == 0) gap = STORE_DEPTH;
         if (prev == 0 || gap >= n) begin
            // history empty or minimum has left the window: rescan oldest to newest, keep oldest on ties
            k = (fill < n) ? fill : n;
            idx = (head + STORE_DEPTH - (k - 1)) % STORE_DEPTH;
            low_now = hist[idx];
            low_at = idx;
            for (int unsigned i = 1; i < k; i++) begin
               idx = (idx + 1) % STORE_DEPTH;
               if (hist[idx] < low_now) begin
                  low_now = hist[idx];
                  low_at = idx;
               end
            end
         end else if (r.sample < low_now) begin
            low_now = r.sample;
            low_at = head;
         end
      end
      head = (head + 1) % STORE_DEPTH;
      if (n == 0 || fill >= n) begin
         res.low_value = low_now;
         res.low_valid = 1'b1;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50) $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[sliding_window_minimum] ERROR");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_ask) begin
         hold_left = HOLD_CYCLES;
         hold_ask = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_low
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lows.size() == 0) begin
            report_mismatch($sformatf("unexpected response value %0d valid %0b",
                                      rsp_payload.low_value, rsp_payload.low_valid));
         end else begin
            want = expected_lows.pop_front();
            if (rsp_payload.low_value !== want.low_value)
               report_mismatch($sformatf("low_value %0d, want %0d",
                                         rsp_payload.low_value, want.low_value));
            if (rsp_payload.low_valid !== want.low_valid)
               report_mismatch($sformatf("low_valid %0b, want %0b",
                                         rsp_payload.low_valid, want.low_valid));
         end
      end
   end

   task automatic send_request(input logic signed [SAMPLE_W-1:0] value, input logic start,
                               input logic skip);
      req_payload_type r;
      r.sample = value;
      r.series_start = start;
      r.lead_skip = skip;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      expected_lows.push_back(predict_low(r));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_lows.size() != 0) @(negedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_LEN_W-1:0] len);
      drain();
      repeat (4) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= len;
      @(negedge clock);
      csr_we <= 1'b0;
      win_len = len;
      clear_history();
   endtask

   task automatic run_series(input int unsigned count, input int unsigned noise_pct);
      shape_type shape;
      int unsigned prefix, step;
      logic signed [SAMPLE_W-1:0] base, value;
      logic start, skip;
      prefix = $urandom_range(3);
      shape = shape_type'($urandom_range(3));
      base = $urandom;
      step = $urandom_range(1, 3);
      for (int unsigned i = 0; i < count; i++) begin
         case (shape)
            SCATTER:   value = $urandom;
            CLUSTERED: value = $signed($urandom_range(7)) - 4;
            RISING:    value = base + i * step;
            default:   value = base - i * step;
         endcase
         if ($urandom_range(15) == 0) value = $urandom_range(1) ? S_MIN : S_MAX;
         start = (i == 0);
         skip = (i < prefix);
         // noise: stray restarts and skipped requests mid-series
         if ($urandom_range(99) < noise_pct) begin
            start = 1'($urandom_range(1));
            skip = 1'($urandom_range(1));
         end
         send_request(value, start, skip);
      end
   endtask

   task automatic run_stream(input logic [WINDOW_LEN_W-1:0] len, input int unsigned total,
                             input int unsigned lo, input int unsigned hi,
                             input int unsigned noise_pct);
      int unsigned done, count;
      write_window(len);
      done = 0;
      while (done < total) begin
         count = $urandom_range(lo, hi);
         if (count > total - done) count = total - done;
         run_series(count, noise_pct);
         done += count;
      end
   endtask

   task automatic test_directed_cases();
      // reset window length still in force
      send_request(3, 1'b1, 1'b0);
      send_request(-3, 1'b0, 1'b0);
      write_window(9'd3);
      send_request(5, 1'b1, 1'b0);
      send_request(S_MAX, 1'b0, 1'b0);
      send_request(S_MIN, 1'b0, 1'b0);
      send_request(100, 1'b0, 1'b1);
      send_request(7, 1'b0, 1'b0);
      send_request(8, 1'b0, 1'b0);
      send_request(9, 1'b0, 1'b0);
      send_request(7, 1'b0, 1'b0);
      send_request(-1, 1'b1, 1'b1);
      send_request(-1, 1'b0, 1'b0);
      send_request(-1, 1'b0, 1'b0);
      send_request(-1, 1'b0, 1'b0);
      write_window(9'd0);
      send_request(0, 1'b1, 1'b1);
      send_request(-9, 1'b0, 1'b1);
      send_request(10, 1'b0, 1'b0);
      send_request(3, 1'b0, 1'b0);
      send_request(S_MAX, 1'b0, 1'b0);
      send_request(S_MIN, 1'b0, 1'b0);
      write_window(9'd1);
      send_request(S_MAX, 1'b1, 1'b0);
      send_request(S_MIN, 1'b0, 1'b0);
      send_request(0, 1'b0, 1'b0);
   endtask

   task automatic test_slow_receiver();
      send_idle_pct = 23;
      recv_idle_pct = 83;
      run_stream(9'd5, 45, 5, 30, 4);
      run_stream(9'd0, 45, 5, 30, 4);
   endtask

   task automatic test_slow_sender();
      send_idle_pct = 83;
      recv_idle_pct = 23;
      run_stream(9'd1, 45, 5, 30, 4);
      run_stream(9'd17, 45, 10, 40, 4);
   endtask

   task automatic test_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // over-long window acts as the full store, so one unbroken series reaches it
      run_stream(9'h1ff, 270, 270, 270, 0);
      run_stream(9'd256, 40, 20, 40, 4);
   endtask

   task automatic test_full_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_window(9'd4);
      send_request($urandom, 1'b1, 1'b0);
      hold_ask = 1'b1;
      run_series(40, 0);
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_slow_receiver();
      test_slow_sender();
      test_full_rate();
      test_full_stall();
      drain();
      repeat (STORE_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && expected_lows.size() == 0) begin
         $display("[sliding_window_minimum] OK");
      end else begin
         $display("[sliding_window_minimum] ERROR");
      end
      $finish;
   end

endmodule

### files.f
sv/swm_pkg.sv
sv/swm_dpath.sv
sv/swm_ctrl.sv
sv/sliding_window_minimum.sv
sim/sliding_window_minimum_test.sv
